// ===== src/tsh_pkg.sv =====
// ----------------------------------------------------------------------------
// tsh_pkg
// Types and codes shared by the thermostat setpoint/hysteresis block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsh_pkg;

  typedef logic signed [11:0] tenths_t;   // temperature / setpoint, 0.1 degree
  typedef logic        [8:0]  band_t;     // hysteresis half band
  typedef logic        [7:0]  angle_t;    // actuator angle, degrees
  typedef logic        [3:0]  key_t;      // keypad event code
  typedef logic        [3:0]  count_t;    // digits held
  typedef logic        [13:0] entry_t;    // digit accumulator, whole degrees
  typedef logic        [2:0]  cfg_idx_t;  // register index
  typedef logic        [11:0] cfg_data_t; // widest register

  // operation codes
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // keypad codes
  localparam key_t KEY_D0    = 4'd0;
  localparam key_t KEY_D9    = 4'd9;
  localparam key_t KEY_CLEAR = 4'd10;
  localparam key_t KEY_COMMIT= 4'd11;
  localparam key_t KEY_P1    = 4'd12;
  localparam key_t KEY_M1    = 4'd13;
  localparam key_t KEY_P10   = 4'd14;
  localparam key_t KEY_M10   = 4'd15;

  // register indexes
  localparam cfg_idx_t REG_MIN_SP   = 3'd0;
  localparam cfg_idx_t REG_MAX_SP   = 3'd1;
  localparam cfg_idx_t REG_BAND     = 3'd2;
  localparam cfg_idx_t REG_HEAT_ANG = 3'd3;
  localparam cfg_idx_t REG_COOL_ANG = 3'd4;

  // register reset values
  localparam tenths_t RST_MIN_SP   = 12'sd0;
  localparam tenths_t RST_MAX_SP   = 12'sd500;
  localparam band_t   RST_BAND     = 9'd10;
  localparam angle_t  RST_HEAT_ANG = 8'd180;
  localparam angle_t  RST_COOL_ANG = 8'd0;

endpackage

`default_nettype wire

// ===== src/thermostat_setpoint_hysteresis.sv =====
// ----------------------------------------------------------------------------
// thermostat_setpoint_hysteresis
// On-off thermostat with keypad setpoint entry and a hysteresis band.
// ----------------------------------------------------------------------------
// One item in, one result out. Each item is either a temperature sample
// (operation 0) or a keypad event (operation 1). Items land in an input
// register; a single pass of add, clamp and compare logic then updates the
// setpoint, digit entry and heater state and loads the result register.
// A new item is taken every cycle while the result side is not stalled: the
// input register refills while the result register is unloaded, so the rate
// is set only by out_ready. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata, by the user only while no item is in flight;
// the block does not enforce this. The setpoint resets to DEFAULT_SETPOINT;
// digit keys beyond MAX_DIGITS are dropped; a commit with no digits does
// nothing; clamping tests the minimum first, then the maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_setpoint_hysteresis #(
  parameter int MAX_DIGITS       = 4,
  parameter int DEFAULT_SETPOINT = 220
) (
  input  wire                 clk,
  input  wire                 rst_n,
  // input channel
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_operation,
  input  tsh_pkg::tenths_t    in_temperature,
  input  tsh_pkg::key_t       in_key_event,
  // result channel
  output logic                out_valid,
  input  wire                 out_ready,
  output tsh_pkg::tenths_t    out_setpoint_now,
  output logic                out_heater_on,
  output tsh_pkg::angle_t     out_actuator_angle,
  output tsh_pkg::count_t     out_digits_held,
  // configuration
  input  wire                 cfg_we,
  input  tsh_pkg::cfg_idx_t   cfg_index,
  input  tsh_pkg::cfg_data_t  cfg_wdata
);
  import tsh_pkg::*;

  // configuration registers
  tenths_t min_sp_r, max_sp_r;
  band_t   band_r;
  angle_t  heat_ang_r, cool_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sp_r   <= RST_MIN_SP;
      max_sp_r   <= RST_MAX_SP;
      band_r     <= RST_BAND;
      heat_ang_r <= RST_HEAT_ANG;
      cool_ang_r <= RST_COOL_ANG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SP:   min_sp_r   <= cfg_wdata;
        REG_MAX_SP:   max_sp_r   <= cfg_wdata;
        REG_BAND:     band_r     <= cfg_wdata[8:0];
        REG_HEAT_ANG: heat_ang_r <= cfg_wdata[7:0];
        REG_COOL_ANG: cool_ang_r <= cfg_wdata[7:0];
        default: ;  // unused indexes: no register
      endcase
    end
  end

  // input register
  logic    s1_valid_r;
  logic    s1_op_r;
  tenths_t s1_temp_r;
  key_t    s1_key_r;
  logic    advance;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_temp_r <= in_temperature;
      s1_key_r  <= in_key_event;
    end
  end

  // thermostat state
  tenths_t setpoint_r, setpoint_nxt;
  tenths_t last_temp_r, last_temp_nxt;
  logic    heating_r, heating_nxt;
  entry_t  entry_r, entry_nxt;
  count_t  count_r, count_nxt;

  logic               sp_load;     // key event that rewrites the setpoint
  logic signed [17:0] sp_cand;     // candidate before clamping
  logic        [16:0] entry_x10;   // committed degrees in tenths
  logic signed [13:0] band_s, temp_s, sp_s;

  assign entry_x10 = ({3'b000, entry_r} << 3) + ({3'b000, entry_r} << 1);

  always_comb begin
    last_temp_nxt = last_temp_r;
    entry_nxt     = entry_r;
    count_nxt     = count_r;
    sp_load       = 1'b0;
    sp_cand       = 18'(setpoint_r);

    if (s1_op_r == OP_TEMP) begin
      last_temp_nxt = s1_temp_r;
    end else begin
      unique case (s1_key_r) inside
        [KEY_D0:KEY_D9]: begin
          if (count_r < 4'(MAX_DIGITS)) begin
            entry_nxt = 14'(entry_x10[13:0] + {10'd0, s1_key_r});
            count_nxt = count_r + 4'd1;
          end
        end
        KEY_CLEAR: begin
          entry_nxt = '0;
          count_nxt = '0;
        end
        KEY_COMMIT: begin
          if (count_r != '0) begin
            sp_load   = 1'b1;
            sp_cand   = $signed({1'b0, entry_x10});
            entry_nxt = '0;
            count_nxt = '0;
          end
        end
        KEY_P1: begin
          sp_load = 1'b1;
          sp_cand = 18'(setpoint_r) + 18'sd10;
        end
        KEY_M1: begin
          sp_load = 1'b1;
          sp_cand = 18'(setpoint_r) - 18'sd10;
        end
        KEY_P10: begin
          sp_load = 1'b1;
          sp_cand = 18'(setpoint_r) + 18'sd100;
        end
        KEY_M10: begin
          sp_load = 1'b1;
          sp_cand = 18'(setpoint_r) - 18'sd100;
        end
        default: ;
      endcase
    end

    // clamp: minimum tested first; with crossed limits, below min gives min, else max
    setpoint_nxt = setpoint_r;
    if (sp_load) begin
      if (sp_cand < 18'(min_sp_r)) begin
        setpoint_nxt = min_sp_r;
      end else if (sp_cand > 18'(max_sp_r)) begin
        setpoint_nxt = max_sp_r;
      end else begin
        setpoint_nxt = sp_cand[11:0];
      end
    end

    // hysteresis on the updated temperature and setpoint
    band_s = $signed({5'b00000, band_r});
    temp_s = 14'(last_temp_nxt);
    sp_s   = 14'(setpoint_nxt);
    heating_nxt = heating_r;
    if (temp_s < sp_s - band_s) begin
      heating_nxt = 1'b1;
    end else if (temp_s > sp_s + band_s) begin
      heating_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r  <= 12'(DEFAULT_SETPOINT);
      last_temp_r <= '0;
      heating_r   <= 1'b0;
      entry_r     <= '0;
      count_r     <= '0;
    end else if (advance) begin
      setpoint_r  <= setpoint_nxt;
      last_temp_r <= last_temp_nxt;
      heating_r   <= heating_nxt;
      entry_r     <= entry_nxt;
      count_r     <= count_nxt;
    end
  end

  // result register
  logic    out_valid_r;
  tenths_t out_sp_r;
  logic    out_heat_r;
  angle_t  out_ang_r;
  count_t  out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sp_r   <= setpoint_nxt;
      out_heat_r <= heating_nxt;
      out_ang_r  <= heating_nxt ? heat_ang_r : cool_ang_r;
      out_cnt_r  <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_setpoint_now   = out_sp_r;
  assign out_heater_on      = out_heat_r;
  assign out_actuator_angle = out_ang_r;
  assign out_digits_held    = out_cnt_r;

endmodule

`default_nettype wire

// ===== src/tsh_checker.sv =====
// ----------------------------------------------------------------------------
// tsh_checker
// Port-level checks for the thermostat block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_checker #(
  parameter int MAX_DIGITS = 4
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input tsh_pkg::tenths_t    out_setpoint_now,
  input wire                 out_heater_on,
  input tsh_pkg::angle_t     out_actuator_angle,
  input tsh_pkg::count_t     out_digits_held
);
  import tsh_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_setpoint_now)
      && $stable(out_heater_on) && $stable(out_actuator_angle)
      && $stable(out_digits_held))
    else $error("stalled result changed");

  // digit entry never exceeds its limit
  a_digits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digits_held <= 4'(MAX_DIGITS))
    else $error("digits held above limit");

  // an accepted item with an empty result side always yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid ##1 1'b1 |=> out_valid)
    else $error("accepted item gave no result");

endmodule

bind thermostat_setpoint_hysteresis tsh_checker #(.MAX_DIGITS(MAX_DIGITS)) u_tsh_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_setpoint_now   (out_setpoint_now),
  .out_heater_on      (out_heater_on),
  .out_actuator_angle (out_actuator_angle),
  .out_digits_held    (out_digits_held)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb - thermostat_setpoint_hysteresis testbench
// Drives temperature samples and keypad events, predicts every result with
// its own thermostat model and checks setpoint, heater, angle and digit count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsh_pkg::*;

  // DUT build
  localparam int MAX_DIGITS       = 4;
  localparam int DEFAULT_SETPOINT = 220;

  // key arithmetic: digit base, and step sizes in tenths of a degree
  localparam int DECIMAL_BASE    = 10;
  localparam int ONE_DEG_TENTHS  = 10;
  localparam int TEN_DEG_TENTHS  = 100;

  // 12 bit signed extremes of a temperature / setpoint field
  localparam int TENTHS_MIN = -2048;
  localparam int TENTHS_MAX = 2047;

  localparam int SETTLE_CYCLES = 6;       // margin past the result path: input register, then result register
  localparam int CYCLE_LIMIT   = 200000;  // hard stop for a hung run
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    tenths_t setpoint;
    logic    heater;
    angle_t  angle;
    count_t  digits;
  } reading_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  logic      in_operation;
  tenths_t   in_temperature;
  key_t      in_key_event;
  logic      out_valid;
  logic      out_ready;
  tenths_t   out_setpoint_now;
  logic      out_heater_on;
  angle_t    out_actuator_angle;
  count_t    out_digits_held;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  // thermostat model state
  int   sp_model;
  int   temp_seen;
  bit   heat_state;
  int   digit_acc;
  int   digit_cnt;
  // model copy of the registers
  int   lim_lo;
  int   lim_hi;
  int   band_w;
  int   ang_heat;
  int   ang_cool;

  reading_t expected_readings[$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int readings_checked;
  int settings_used;
  int bad_readings;
  int cycle_count;

  thermostat_setpoint_hysteresis #(
    .MAX_DIGITS      (MAX_DIGITS),
    .DEFAULT_SETPOINT(DEFAULT_SETPOINT)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_temperature    (in_temperature),
    .in_key_event      (in_key_event),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_setpoint_now  (out_setpoint_now),
    .out_heater_on     (out_heater_on),
    .out_actuator_angle(out_actuator_angle),
    .out_digits_held   (out_digits_held),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings still expected",
               cycle_count, expected_readings.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Model
  // ------------------------------------------------------------------------
  function automatic int clamp_setpoint(input int v);
    // min is tested first, so an inverted pair still gives a defined answer
    if (v < lim_lo) return lim_lo;
    if (v > lim_hi) return lim_hi;
    return v;
  endfunction

  task automatic reset_model();
    lim_lo     = int'(RST_MIN_SP);
    lim_hi     = int'(RST_MAX_SP);
    band_w     = int'(RST_BAND);
    ang_heat   = int'(RST_HEAT_ANG);
    ang_cool   = int'(RST_COOL_ANG);
    sp_model   = DEFAULT_SETPOINT;
    temp_seen  = 0;
    heat_state = 1'b0;
    digit_acc  = 0;
    digit_cnt  = 0;
  endtask

  // One accepted item -> one expected reading.
  task automatic predict_thermostat(input logic op, input tenths_t t, input key_t k);
    reading_t r;
    if (op == OP_TEMP) begin
      temp_seen = t;
    end else if (k <= KEY_D9) begin
      // digits past the limit are dropped silently
      if (digit_cnt < MAX_DIGITS) begin
        digit_acc = digit_acc * DECIMAL_BASE + int'(k);
        digit_cnt++;
      end
    end else begin
      case (k)
        KEY_CLEAR: begin
          digit_acc = 0;
          digit_cnt = 0;
        end
        KEY_COMMIT: begin
          // empty commit leaves everything alone
          if (digit_cnt != 0) begin
            sp_model  = clamp_setpoint(digit_acc * ONE_DEG_TENTHS);
            digit_acc = 0;
            digit_cnt = 0;
          end
        end
        KEY_P1:  sp_model = clamp_setpoint(sp_model + ONE_DEG_TENTHS);
        KEY_M1:  sp_model = clamp_setpoint(sp_model - ONE_DEG_TENTHS);
        KEY_P10: sp_model = clamp_setpoint(sp_model + TEN_DEG_TENTHS);
        default: sp_model = clamp_setpoint(sp_model - TEN_DEG_TENTHS);
      endcase
    end

    // band re-applied on every item, full precision compare
    if (temp_seen < sp_model - band_w)
      heat_state = 1'b1;
    else if (temp_seen > sp_model + band_w)
      heat_state = 1'b0;

    r.setpoint = tenths_t'(sp_model);
    r.heater   = heat_state;
    r.angle    = angle_t'(heat_state ? ang_heat : ang_cool);
    r.digits   = count_t'(digit_cnt);
    expected_readings.push_back(r);
  endtask

  task automatic check_reading();
    reading_t got;
    reading_t want;
    got = '{out_setpoint_now, out_heater_on, out_actuator_angle, out_digits_held};
    if (expected_readings.size() == 0) begin
      bad_readings++;
      if (bad_readings <= REPORT_MAX)
        $display("%0t: reading with nothing expected: setpoint %0d heater %0b angle %0d digits %0d",
                 $time, $signed(got.setpoint), got.heater, got.angle, got.digits);
    end else begin
      want = expected_readings.pop_front();
      readings_checked++;
      if (got.setpoint !== want.setpoint || got.heater !== want.heater ||
          got.angle !== want.angle || got.digits !== want.digits) begin
        bad_readings++;
        if (bad_readings <= REPORT_MAX)
          $display("%0t: reading %0d wrong (exp/got): setpoint %0d/%0d heater %0b/%0b angle %0d/%0d digits %0d/%0d",
                   $time, readings_checked, $signed(want.setpoint), $signed(got.setpoint),
                   want.heater, got.heater, want.angle, got.angle, want.digits, got.digits);
      end
    end
  endtask

  // Both handshakes sampled at the edge, before any of this edge's updates.
  // Results are checked before the new item is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        check_reading();
      if (in_valid && in_ready)
        predict_thermostat(in_operation, in_temperature, in_key_event);
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge the item is taken, with
  // in_valid still high so a following item can go out back to back.
  task automatic send_item(input logic op, input tenths_t t, input key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_temperature <= t;
    in_key_event   <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry random junk, the block must ignore them
  task automatic send_temp(input int t);
    send_item(OP_TEMP, tenths_t'(t), key_t'($urandom_range(15)));
  endtask

  task automatic send_key(input key_t k);
    send_item(OP_KEY, tenths_t'($urandom_range(4095)), k);
  endtask

  // Keys in a decimal number, most significant digit first.
  task automatic enter_number(input int value, input int ndig);
    int i;
    int div;
    for (i = 0; i < ndig; i++) begin
      div = 1;
      repeat (ndig - 1 - i) div *= DECIMAL_BASE;
      send_key(key_t'((value / div) % DECIMAL_BASE));
    end
  endtask

  // Stop sending and wait until every reading is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= cfg_data_t'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MIN_SP:   lim_lo   = int'(tenths_t'(value));
      REG_MAX_SP:   lim_hi   = int'(tenths_t'(value));
      REG_BAND:     band_w   = int'(band_t'(value));
      REG_HEAT_ANG: ang_heat = int'(angle_t'(value));
      default:      ang_cool = int'(angle_t'(value));
    endcase
  endtask

  // New register set, only ever written with the block drained.
  task automatic configure(input int lo, input int hi, input int band,
                           input int heat, input int cool);
    settle();
    set_reg(REG_MIN_SP, lo);
    set_reg(REG_MAX_SP, hi);
    set_reg(REG_BAND, band);
    set_reg(REG_HEAT_ANG, heat);
    set_reg(REG_COOL_ANG, cool);
    settings_used++;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Reset registers: setpoint 220, band 10. Walks the band from both sides.
  task automatic test_reset_state();
    send_temp(TENTHS_MIN);                          // far below: heater on
    send_temp(DEFAULT_SETPOINT + int'(RST_BAND));   // on the edge: holds on
    send_temp(TENTHS_MAX);                          // far above: heater off
  endtask

  // Digit entry: empty commit, too many digits, clear, commit of zero.
  task automatic test_digit_entry();
    send_key(KEY_COMMIT);        // nothing held, nothing changes
    enter_number(12349, 5);      // fifth digit dropped
    send_key(KEY_COMMIT);        // 1234 deg -> clamped to max
    enter_number(7, 1);
    send_key(KEY_CLEAR);
    enter_number(0, 1);
    send_key(KEY_COMMIT);        // zero -> sits on min
  endtask

  task automatic test_step_keys();
    send_key(KEY_P10);
    send_key(KEY_M1);
  endtask

  // Full 12 bit limits, zero band, widest angle.
  task automatic test_wide_limits();
    configure(TENTHS_MIN, TENTHS_MAX, 0, 255, 0);
    enter_number(9999, MAX_DIGITS);
    send_key(KEY_COMMIT);        // 99990 tenths saturates onto max
    send_key(KEY_P1);            // already at max
    send_temp(TENTHS_MIN);
  endtask

  // min above max, widest band: clamp answers alternate between the two.
  task automatic test_inverted_limits();
    configure(300, 100, 511, 0, 255);
    send_key(KEY_M10);
    send_key(KEY_P1);
    send_temp(TENTHS_MAX);
  endtask

  // Mostly well-formed traffic around the current setpoint, plus noise.
  task automatic test_random_traffic(input int n, input int snd_pct, input int rcv_pct);
    int sent;
    int pick;
    int ndig;
    int t;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // close to the band edges so the heater really toggles
        t = sp_model + int'($urandom_range(2 * band_w + 60)) - band_w - 30;
        if (t < TENTHS_MIN) t = TENTHS_MIN;
        if (t > TENTHS_MAX) t = TENTHS_MAX;
        send_temp(t);
        sent++;
      end else if (pick < 45) begin
        send_temp(int'(tenths_t'($urandom_range(4095))));
        sent++;
      end else if (pick < 75) begin
        // digit run ending in a commit, one too many now and then
        ndig = $urandom_range(MAX_DIGITS + 1, 1);
        repeat (ndig) send_key(key_t'($urandom_range(KEY_D9, KEY_D0)));
        sent += ndig + 1;
        if ($urandom_range(9) == 0) begin
          send_key(KEY_CLEAR);
          sent++;
        end
        send_key(KEY_COMMIT);
      end else if (pick < 90) begin
        send_key(key_t'($urandom_range(KEY_M10, KEY_P1)));
        sent++;
      end else begin
        send_key(key_t'($urandom_range(15)));
        sent++;
      end
    end
  endtask

  initial begin
    reset_model();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_TEMP;
    in_temperature = '0;
    in_key_event   = KEY_D0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_MIN_SP;
    cfg_wdata      = '0;
    send_idle_pct  = 37;
    recv_idle_pct  = 78;
    items_sent       = 0;
    readings_checked = 0;
    settings_used    = 1;
    bad_readings     = 0;
    cycle_count      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_digit_entry();
    test_step_keys();
    test_wide_limits();
    test_inverted_limits();

    configure(-1000, 2000, $urandom_range(60), $urandom_range(255), $urandom_range(255));
    test_random_traffic(234, 37, 78);
    configure(-200, 300, 5, 90, 45);
    test_random_traffic(234, 78, 37);
    configure(int'(RST_MIN_SP), int'(RST_MAX_SP), int'(RST_BAND),
              int'(RST_HEAT_ANG), int'(RST_COOL_ANG));
    test_random_traffic(234, 0, 0);
    settle();

    $display("%0d items driven, %0d readings checked over %0d register settings",
             items_sent, readings_checked, settings_used);
    $display("covered band edges, digit overflow, empty commit, clear, step keys, inverted limits");
    if (bad_readings == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tsh_pkg.sv
src/thermostat_setpoint_hysteresis.sv
src/tsh_checker.sv
verif/tb.sv
